// ===== sv/udpcs_pkg.sv =====
// shared types and constants for the udp checksum stream unit
package udpcs_pkg;

  // ip protocol number of udp, added into the pseudo header
  localparam logic [15:0] UDP_PROTO_NUM = 16'd17;
  localparam logic [15:0] ODD_MASK      = 16'hFF00;
  localparam logic [31:0] HI_HALF_MASK  = 32'hFFFF0000;
  localparam logic [31:0] LO_HALF_MASK  = 32'h0000FFFF;
  localparam logic [15:0] INDEX_MAX     = 16'hFFFF;
  // word index of the udp checksum field, summed as zero
  localparam logic [15:0] CSUM_WORD     = 16'd3;
  localparam logic [15:0] LEN_WORD      = 16'd2;

  typedef struct packed {
    logic [15:0] seg_word;
    logic        first_word;
    logic        last_word;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } udpcs_item_t;

  typedef struct packed {
    logic [15:0] checksum_out;
    logic        length_mismatch;
  } udpcs_result_t;

endpackage

// ===== sv/udp_checksum_stream_unit.sv =====
// udp over ipv4 checksum on a 16-bit word stream, top level
// an accepted last word passes through the input register and then the result register to m_tvalid
// throughput: one item per cycle, unless a held result meets a full output with m_tready low
// the output register lets new items enter while a result waits for m_tready, until a further last word is held
// reset: synchronous active-high rst clears the input and output stages and the segment state
module udp_checksum_stream_unit import udpcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // seg_word[15:0], src_addr[47:16], dst_addr[79:48]
  input  logic        s_tlast,   // last_word
  input  logic        s_tuser,   // first_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // checksum_out[15:0]
  output logic        m_tuser    // length_mismatch
);

  logic          in_valid;
  udpcs_item_t   in_item;
  logic          out_valid;
  udpcs_result_t out_data;
  logic          has_result;
  udpcs_result_t result;
  logic          advance;
  logic          step;

  // the held item moves on unless its result finds the output full and m_tready low
  assign advance  = !out_valid || m_tready || !has_result;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.seg_word   <= s_tdata[15:0];
      in_item.src_addr   <= s_tdata[47:16];
      in_item.dst_addr   <= s_tdata[79:48];
      in_item.last_word  <= s_tlast;
      in_item.first_word <= s_tuser;
    end
  end

  udpcs_sum_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (in_item),
    .has_result (has_result),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data.checksum_out;
  assign m_tuser  = out_data.length_mismatch;

endmodule

// ===== sv/udpcs_sum_core.sv =====
// running ones' complement sum, segment state and final fold for one item
module udpcs_sum_core import udpcs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  udpcs_item_t   item,
  output logic          has_result,
  output udpcs_result_t result
);

  logic [31:0] running_sum;
  logic [15:0] word_index;
  logic [15:0] segment_length;
  logic        in_segment;
  logic [15:0] head0;
  logic [15:0] head1;

  logic [31:0] running_sum_next;
  logic [15:0] word_index_next;
  logic [15:0] segment_length_next;
  logic        in_segment_next;

  logic [31:0] sum_eff;
  logic [15:0] idx_eff;
  logic [15:0] len_eff;
  logic [15:0] head0_eff;
  logic [15:0] head1_eff;
  logic        active;
  logic [17:0] addr_sum;
  logic [17:0] add_part;
  logic [31:0] total;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [16:0] want;

  // contribution of word idx under length len
  function automatic logic [15:0] word_part(input logic [15:0] idx, input logic [15:0] w,
                                            input logic [15:0] len);
    logic [16:0] off;
    logic [16:0] len17;
    off   = {idx, 1'b0};
    len17 = {1'b0, len};
    if (idx == CSUM_WORD || off >= len17) begin
      word_part = '0;
    end else if (off + 17'd1 == len17) begin
      word_part = w & ODD_MASK;
    end else begin
      word_part = w;
    end
  endfunction

  // pseudo header address halves, taken on the first word
  assign addr_sum = 18'((item.src_addr & HI_HALF_MASK) >> 16)
                  + 18'(item.src_addr & LO_HALF_MASK)
                  + 18'((item.dst_addr & HI_HALF_MASK) >> 16)
                  + 18'(item.dst_addr & LO_HALF_MASK);

  // state as seen by this item, a first word restarts the segment
  always_comb begin
    if (item.first_word) begin
      sum_eff   = 32'(addr_sum);
      idx_eff   = '0;
      len_eff   = '0;
      head0_eff = '0;
      head1_eff = '0;
    end else begin
      sum_eff   = running_sum;
      idx_eff   = word_index;
      len_eff   = segment_length;
      head0_eff = head0;
      head1_eff = head1;
    end
    active = item.first_word || in_segment;
  end

  // add this item's words and advance the segment state
  always_comb begin
    segment_length_next = len_eff;
    add_part            = '0;
    if (idx_eff == LEN_WORD) begin
      segment_length_next = item.seg_word;
      add_part = 18'(word_part(16'd0, head0_eff, item.seg_word))
               + 18'(word_part(16'd1, head1_eff, item.seg_word))
               + 18'(word_part(LEN_WORD, item.seg_word, item.seg_word));
    end else if (idx_eff > LEN_WORD) begin
      add_part = 18'(word_part(idx_eff, item.seg_word, len_eff));
    end
    running_sum_next = sum_eff + 32'(add_part);
    word_index_next  = (idx_eff == INDEX_MAX) ? idx_eff : idx_eff + 16'd1;
    in_segment_next  = !item.last_word;
  end

  // pseudo header length and protocol, carry fold and inversion
  always_comb begin
    total  = running_sum_next + 32'(segment_length_next) + 32'(UDP_PROTO_NUM);
    fold1  = 17'(total[15:0]) + 17'(total[31:16]);
    fold2  = 17'(fold1[15:0]) + 17'(fold1[16]);
    want   = (17'(segment_length_next) + 17'd1) >> 1;
    has_result             = active && item.last_word;
    result.checksum_out    = ~fold2[15:0];
    result.length_mismatch = (17'(word_index_next) != want);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      word_index     <= '0;
      segment_length <= '0;
      in_segment     <= 1'b0;
    end else if (step && active) begin
      running_sum    <= running_sum_next;
      word_index     <= word_index_next;
      segment_length <= segment_length_next;
      in_segment     <= in_segment_next;
    end
  end

  // header words held until the length is known
  always_ff @(posedge clk) begin
    if (step && active) begin
      if (idx_eff == 16'd0) begin
        head0 <= item.seg_word;
      end
      if (idx_eff == 16'd1) begin
        head1 <= item.seg_word;
      end
    end
  end

endmodule

// ===== sv/udpcs_checker.sv =====
// port-level checks for the udp checksum stream unit, bound to the top level
module udpcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // an empty output never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a new result comes from an accepted last word
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a last word");

endmodule

bind udp_checksum_stream_unit udpcs_checker u_udpcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/tb.sv =====
// self-checking testbench for the udp checksum stream unit
module tb;
  import udpcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_ITEMS   = 900;
  localparam int QUIET_AFTER = 800;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 10;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // seg_word[15:0], src_addr[47:16], dst_addr[79:48]
  logic        s_tlast;   // last_word
  logic        s_tuser;   // first_word
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // checksum_out[15:0]
  logic        m_tuser;   // length_mismatch

  udp_checksum_stream_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // directed stimulus row; cs and mm hold a hand-computed result where known is set
  typedef struct packed {
    logic [15:0] w;
    logic        first;
    logic        last;
    logic [31:0] src;
    logic [31:0] dst;
    logic        known;
    logic [15:0] cs;
    logic        mm;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // one-word segments at the address extremes
    '{16'h0000, 1'b1, 1'b1, 32'h00000000, 32'h00000000, 1'b1, 16'hFFEE, 1'b1},
    '{16'hFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 16'hFFEE, 1'b1},
    // stray word while no segment is open
    '{16'hFFFF, 1'b0, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 16'h0000, 1'b0},
    // bare header, length 8, zero addresses
    '{16'h0000, 1'b1, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h0008, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 32'h00000000, 32'h00000000, 1'b1, 16'hFFDE, 1'b0},
    // odd length, last byte masked, checksum word skipped
    '{16'h1234, 1'b1, 1'b0, 32'hC0A80001, 32'hC0A800C7, 1'b0, 16'h0000, 1'b0},
    '{16'h0035, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h0009, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'hBEEF, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'hABCD, 1'b0, 1'b1, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    // open segment dropped by a new first word
    '{16'hAAAA, 1'b1, 1'b0, 32'h12345678, 32'h9ABCDEF0, 1'b0, 16'h0000, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h0001, 1'b1, 1'b0, 32'hFEDCBA98, 32'h76543210, 1'b0, 16'h0000, 1'b0},
    '{16'h0002, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h000C, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h1111, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h8000, 1'b0, 1'b1, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    // two-word segment, length never seen
    '{16'hFFFF, 1'b1, 1'b0, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    // length 1: words past the length ignored but counted
    '{16'h7F80, 1'b1, 1'b0, 32'h80000000, 32'h00000001, 1'b0, 16'h0000, 1'b0},
    '{16'h0101, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'h0001, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 32'h00000000, 32'h00000000, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 16'h0000, 1'b0}
  };

  // checksum predictor state
  logic [31:0] acc_sum;
  logic [15:0] word_cnt;
  logic [15:0] udp_len;
  logic        seg_open;
  logic [15:0] hw0;
  logic [15:0] hw1;

  udpcs_result_t csum_q [$];
  int            err_cnt;
  int            seg_items;
  int            stall_left;
  int            idle_cycles;
  bit            quiet;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(input string msg);
    if (err_cnt < 100)
      $display("mismatch at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // share of one segment word that falls inside the udp length
  function automatic logic [31:0] length_part(input logic [15:0] idx, input logic [15:0] w);
    logic [16:0] off;
    off = {idx, 1'b0};
    if (idx == CSUM_WORD || off >= {1'b0, udp_len})
      return 32'd0;
    if (off + 17'd1 == {1'b0, udp_len})
      return {16'd0, w & ODD_MASK};
    return {16'd0, w};
  endfunction

  // advance the checksum state by one word; returns 1 when a result is due
  function automatic bit udp_csum_step(input logic [15:0] w, input logic first,
                                       input logic last, input logic [31:0] src,
                                       input logic [31:0] dst, output udpcs_result_t res);
    logic [31:0] s;
    logic [16:0] want_words;
    res = '0;
    if (first) begin
      acc_sum  = ((src & HI_HALF_MASK) >> 16) + (src & LO_HALF_MASK)
               + ((dst & HI_HALF_MASK) >> 16) + (dst & LO_HALF_MASK);
      word_cnt = '0;
      udp_len  = '0;
      hw0      = '0;
      hw1      = '0;
      seg_open = 1'b1;
    end else if (!seg_open) begin
      return 1'b0;
    end
    // header words wait for the length in word 2
    if (word_cnt == 16'd0) begin
      hw0 = w;
    end else if (word_cnt == 16'd1) begin
      hw1 = w;
    end else if (word_cnt == LEN_WORD) begin
      udp_len = w;
      acc_sum = acc_sum + length_part(16'd0, hw0) + length_part(16'd1, hw1)
              + length_part(LEN_WORD, w);
    end else begin
      acc_sum = acc_sum + length_part(word_cnt, w);
    end
    if (word_cnt != INDEX_MAX)
      word_cnt = word_cnt + 16'd1;
    if (!last)
      return 1'b0;
    // pseudo header length and protocol, then fold and invert
    s = acc_sum + {16'd0, udp_len} + {16'd0, UDP_PROTO_NUM};
    while (s[31:16] != 16'd0)
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    want_words          = ({1'b0, udp_len} + 17'd1) >> 1;
    res.checksum_out    = ~s[15:0];
    res.length_mismatch = ({1'b0, word_cnt} != want_words);
    seg_open            = 1'b0;
    return 1'b1;
  endfunction

  // drive one item from a falling edge until it is accepted
  task automatic send_item(input logic [15:0] w, input logic first, input logic last,
                           input logic [31:0] src, input logic [31:0] dst,
                           input logic known, input udpcs_result_t known_res);
    udpcs_result_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tdata  <= {dst, src, w};
    s_tlast  <= last;
    s_tuser  <= first;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    if (udp_csum_step(w, first, last, src, dst, res))
      csum_q.push_back(known ? known_res : res);
    @(negedge clk);
  endtask

  // one segment with random content; word 2 carries len
  task automatic send_segment(input int nw, input logic [15:0] len, input bit close);
    logic [31:0]   src;
    logic [31:0]   dst;
    logic [15:0]   w;
    udpcs_result_t none;
    src  = $urandom;
    dst  = $urandom;
    none = '0;
    for (int i = 0; i < nw; i++) begin
      w = (i == 2) ? len : 16'($urandom);
      send_item(w, i == 0, close && i == nw - 1, (i == 0) ? src : $urandom,
                (i == 0) ? dst : $urandom, 1'b0, none);
      seg_items++;
    end
  endtask

  // receiver backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result with the oldest expected checksum
  always @(posedge clk) begin : result_check
    udpcs_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (csum_q.size() == 0) begin
        report($sformatf("unexpected result %h/%b", m_tdata, m_tuser));
      end else begin
        exp_res = csum_q.pop_front();
        if (m_tdata !== exp_res.checksum_out)
          report($sformatf("checksum %h, expected %h", m_tdata, exp_res.checksum_out));
        if (m_tuser !== exp_res.length_mismatch)
          report($sformatf("length flag %b, expected %b", m_tuser,
                           exp_res.length_mismatch));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // main sequence
  initial begin : main_seq
    int            pick;
    int            nw;
    bit            odd;
    udpcs_result_t known_res;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    s_tuser     = 1'b0;
    err_cnt     = 0;
    seg_items   = 0;
    stall_left  = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    acc_sum     = '0;
    word_cnt    = '0;
    udp_len     = '0;
    seg_open    = 1'b0;
    hw0         = '0;
    hw1         = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      known_res.checksum_out    = DIR_TAB[r].cs;
      known_res.length_mismatch = DIR_TAB[r].mm;
      send_item(DIR_TAB[r].w, DIR_TAB[r].first, DIR_TAB[r].last, DIR_TAB[r].src,
                DIR_TAB[r].dst, DIR_TAB[r].known, known_res);
    end

    // random segments, mostly well formed
    while (seg_items < SEG_ITEMS) begin
      quiet = (seg_items >= QUIET_AFTER);
      pick  = $urandom_range(0, 99);
      if (pick < 70) begin
        nw  = $urandom_range(3, 24);
        odd = $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0)
          send_segment(nw + $urandom_range(1, 3), 16'(2 * nw - int'(odd)), 1'b1);
        else
          send_segment(nw, 16'(2 * nw - int'(odd)), 1'b1);
      end else if (pick < 80) begin
        // too short to carry a length
        send_segment($urandom_range(1, 2), 16'd0, 1'b1);
      end else if (pick < 88) begin
        // left open, dropped by the next first word
        send_segment($urandom_range(1, 6), 16'($urandom_range(6, 40)), 1'b0);
      end else if (pick < 94) begin
        // stray words with no first flag
        repeat ($urandom_range(1, 3))
          send_item(16'($urandom), 1'b0, 1'($urandom), $urandom, $urandom, 1'b0, known_res);
      end else begin
        // arbitrary length word
        send_segment($urandom_range(3, 10), 16'($urandom), 1'b1);
      end
    end
    send_segment(5, 16'd10, 1'b1);
    s_tvalid <= 1'b0;

    // drain
    while (csum_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (csum_q.size() != 0)
      report($sformatf("%0d checksums never arrived", csum_q.size()));
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/udpcs_pkg.sv
sv/udpcs_sum_core.sv
sv/udp_checksum_stream_unit.sv
sv/udpcs_checker.sv
tb/sv/tb.sv
